/* rtl/rdb_pkg.sv */
// rdb_pkg: action and status codes, controller states and the result record
// for the reversible deque buffer. No dependencies.
`timescale 1ns / 1ps

package rdb_pkg;

    localparam int ELEM_W = 32;
    localparam int POS_W  = 6;

    typedef enum logic [2:0] {
        ACT_PRINT      = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_POP_FRONT  = 3'd4,
        ACT_REVERSE    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PRINT = 1'b1
    } state_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic [POS_W-1:0]         position;
        logic                     last;
        status_t                  status;
    } result_t;

endpackage

/* rtl/rdb_in_if.sv */
// rdb_in_if: request channel of the deque buffer, valid/ready with action and value.
// Depends on nothing.
`timescale 1ns / 1ps

interface rdb_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

/* rtl/rdb_out_if.sv */
// rdb_out_if: result channel of the deque buffer, valid/ready with one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface rdb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element;
    logic [5:0]         position;
    logic               last;
    logic [1:0]         status;

    modport source (output valid, output element, output position, output last,
                    output status, input ready);
    modport sink (input valid, input element, input position, input last,
                  input status, output ready);
endinterface

/* rtl/rdb_ram.sv */
// rdb_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/rdb_out_fifo.sv */
// rdb_out_fifo: two-entry result queue that decouples the controller from the
// receiver. Depends on rdb_pkg.
`timescale 1ns / 1ps

module rdb_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rdb_pkg::result_t push_data,
    input  logic            pop,
    output rdb_pkg::result_t head_data,
    output logic            not_empty,
    output logic [1:0]      count
);

    rdb_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign not_empty = count_reg != 2'd0;
    assign count     = count_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) push |-> count_reg != 2'd2)
        else $error("result queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_reg != 2'd0)
        else $error("result queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("result queue count lost a write");
`endif

endmodule

/* rtl/reversible_deque_buffer.sv */
// reversible_deque_buffer: top level, controller with head pointer, occupancy and
// direction flag around the word store. Depends on rdb_pkg, rdb_in_if, rdb_out_if,
// rdb_ram and rdb_out_fifo.
`timescale 1ns / 1ps

// Usage:
//   cmd carries one request: an action (print, push back, push front, pop back,
//   pop front, reverse) and a value. rsp returns results: element, position,
//   last and status. Both are valid/ready; a transfer happens when both are high.
//   Push and pop requests give one status result (ok, full or empty), written
//   to the result queue at the accepting edge and offered on rsp the cycle after.
//   Reverse flips a direction flag and gives no result. Print gives one result
//   per stored word, front to back, the final one marked with last; an empty
//   print gives a single empty result.
//   Throughput: push, pop and reverse accept one request every cycle while the
//   two-entry result queue has room. Print reads the store through its registered
//   read port, issuing a read only when its result is sure to find room in the
//   queue, so a read may start before the one ahead of it has returned; no new request
//   is accepted until the print's last read has returned.
//   When the receiver stalls, results wait in the two-entry queue; once it is
//   full, reads and request acceptance pause.
//   Reset (rst_n low, asynchronous) empties the deque and clears the flag and
//   the result queue. Store contents need no clearing.
module reversible_deque_buffer #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    rdb_in_if.sink    cmd,
    rdb_out_if.source rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    rdb_pkg::state_t state_reg;
    rdb_pkg::state_t state_next;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             rev_reg;
    logic             rev_next;
    logic [PTR_W-1:0] idx_reg;
    logic [PTR_W-1:0] idx_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic [PTR_W-1:0] rd_pos_reg;
    logic [PTR_W-1:0] rd_pos_next;
    logic             rd_last_reg;
    logic             rd_last_next;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [PTR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic             fifo_push;
    rdb_pkg::result_t fifo_din;
    rdb_pkg::result_t fifo_head;
    logic             fifo_not_empty;
    logic [1:0]       fifo_count;

    logic             accept;
    logic             at_tail;
    logic [PTR_W-1:0] print_k;
    logic             print_last;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] offs);
        logic [PTR_W:0] s;
        s = {1'b0, base} + {1'b0, offs};
        if (s >= (PTR_W + 1)'(DEPTH))
        begin
            s = s - (PTR_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic rdb_pkg::result_t status_result(input rdb_pkg::status_t st);
        rdb_pkg::result_t r;
        r.element  = '0;
        r.position = '0;
        r.last     = 1'b1;
        r.status   = st;
        return r;
    endfunction

    assign cmd.ready = (state_reg == rdb_pkg::ST_IDLE) && !rd_pend_reg
                       && (fifo_count != 2'd2);
    assign accept    = cmd.valid && cmd.ready;

    // logical index to physical offset from head, walking backward when reversed
    assign print_k    = rev_reg ? PTR_W'(occ_reg - OCC_W'(1) - OCC_W'(idx_reg)) : idx_reg;
    assign print_last = (OCC_W'(idx_reg) + OCC_W'(1)) == occ_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        occ_next     = occ_reg;
        rev_next     = rev_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        rd_pos_next  = rd_pos_reg;
        rd_last_next = rd_last_reg;
        ram_we       = 1'b0;
        ram_waddr    = wrap_add(head_reg, occ_reg[PTR_W-1:0]);
        ram_wdata    = WORD_BITS'(cmd.value);
        ram_re       = 1'b0;
        ram_raddr    = wrap_add(head_reg, print_k);
        fifo_push    = 1'b0;
        fifo_din     = status_result(rdb_pkg::STAT_OK);
        at_tail      = 1'b0;

        if (rd_pend_reg)
        begin
            fifo_push         = 1'b1;
            fifo_din.element  = rdb_pkg::ELEM_W'(signed'(ram_rdata));
            fifo_din.position = rdb_pkg::POS_W'(rd_pos_reg);
            fifo_din.last     = rd_last_reg;
            fifo_din.status   = rdb_pkg::STAT_OK;
        end

        case (state_reg)
            rdb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (rdb_pkg::action_t'(cmd.action))
                        rdb_pkg::ACT_PRINT:
                        begin
                            if (occ_reg == '0)
                            begin
                                fifo_push = 1'b1;
                                fifo_din  = status_result(rdb_pkg::STAT_EMPTY);
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = rdb_pkg::ST_PRINT;
                            end
                        end
                        rdb_pkg::ACT_PUSH_BACK, rdb_pkg::ACT_PUSH_FRONT:
                        begin
                            fifo_push = 1'b1;
                            if (occ_reg == OCC_W'(DEPTH))
                            begin
                                fifo_din = status_result(rdb_pkg::STAT_FULL);
                            end
                            else
                            begin
                                at_tail = (rdb_pkg::action_t'(cmd.action)
                                           == rdb_pkg::ACT_PUSH_BACK) != rev_reg;
                                if (!at_tail)
                                begin
                                    head_next = (head_reg == '0) ? PTR_W'(DEPTH - 1)
                                                                 : head_reg - PTR_W'(1);
                                    ram_waddr = head_next;
                                end
                                ram_we   = 1'b1;
                                occ_next = occ_reg + OCC_W'(1);
                                fifo_din = status_result(rdb_pkg::STAT_OK);
                            end
                        end
                        rdb_pkg::ACT_POP_BACK, rdb_pkg::ACT_POP_FRONT:
                        begin
                            fifo_push = 1'b1;
                            if (occ_reg == '0)
                            begin
                                fifo_din = status_result(rdb_pkg::STAT_EMPTY);
                            end
                            else
                            begin
                                at_tail = (rdb_pkg::action_t'(cmd.action)
                                           == rdb_pkg::ACT_POP_BACK) != rev_reg;
                                if (!at_tail)
                                begin
                                    head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0
                                                : head_reg + PTR_W'(1);
                                end
                                occ_next = occ_reg - OCC_W'(1);
                                fifo_din = status_result(rdb_pkg::STAT_OK);
                            end
                        end
                        rdb_pkg::ACT_REVERSE:
                        begin
                            rev_next = ~rev_reg;
                        end
                        default:
                        begin
                            state_next = rdb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rdb_pkg::ST_PRINT:
            begin
                // issue a read only when its result is sure to find room in the queue
                if ((fifo_count + 2'(rd_pend_reg)) < 2'd2)
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_pos_next  = idx_reg;
                    rd_last_next = print_last;
                    if (print_last)
                    begin
                        state_next = rdb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + PTR_W'(1);
                    end
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = rdb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rdb_pkg::ST_IDLE;
            head_reg    <= '0;
            occ_reg     <= '0;
            rev_reg     <= 1'b0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            occ_reg     <= occ_next;
            rev_reg     <= rev_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg  <= rd_pos_next;
        rd_last_reg <= rd_last_next;
    end

    rdb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    rdb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_din),
        .pop       (rsp.valid && rsp.ready),
        .head_data (fifo_head),
        .not_empty (fifo_not_empty),
        .count     (fifo_count)
    );

    assign rsp.valid    = fifo_not_empty;
    assign rsp.element  = fifo_head.element;
    assign rsp.position = fifo_head.position;
    assign rsp.last     = fifo_head.last;
    assign rsp.status   = fifo_head.status;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rdb_pkg::ST_PRINT |-> occ_reg != '0)
        else $error("print walk on an empty deque");
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> rd_pend_reg && fifo_push)
        else $error("store read did not reach the result queue");
`endif

endmodule
